/* sv/fbds_pkg.sv */
// ============================================================================
// fbds_pkg - shared constants and tables for the fractional baud divisor search
// Holds the fractional-divider ROM, field widths and the divider request/response types.
// ============================================================================
package fbds_pkg;

    localparam int CLOCK_W   = 28;
    localparam int BAUD_W    = 24;
    localparam int DL_W      = 16;
    localparam int FRAC_W    = 4;
    localparam int ROM_SIZE  = 72;
    localparam int TABLE_ENTRIES_DEF = 72;
    localparam int OVERSAMPLE_DEF    = 16;
    localparam logic [CLOCK_W-1:0] CLOCK_RESET = 28'd25000000;

    // Operand width of the shared divider: the dividend clk*mul*256 needs 28+4+8 bits.
    localparam int DIV_W = 40;
    localparam int DIV_CNT_W = $clog2(DIV_W + 1);

    typedef logic [FRAC_W-1:0] frac_t;

    typedef struct packed {
        logic           start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic           done;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

    function automatic frac_t rom_add(input logic [6:0] idx);
        frac_t r;
        unique case (idx)
            7'd0:  r = 4'd0;  7'd1:  r = 4'd1;  7'd2:  r = 4'd1;  7'd3:  r = 4'd1;
            7'd4:  r = 4'd1;  7'd5:  r = 4'd1;  7'd6:  r = 4'd1;  7'd7:  r = 4'd1;
            7'd8:  r = 4'd1;  7'd9:  r = 4'd2;  7'd10: r = 4'd1;  7'd11: r = 4'd2;
            7'd12: r = 4'd1;  7'd13: r = 4'd2;  7'd14: r = 4'd1;  7'd15: r = 4'd3;
            7'd16: r = 4'd2;  7'd17: r = 4'd3;  7'd18: r = 4'd1;  7'd19: r = 4'd4;
            7'd20: r = 4'd3;  7'd21: r = 4'd2;  7'd22: r = 4'd3;  7'd23: r = 4'd4;
            7'd24: r = 4'd1;  7'd25: r = 4'd5;  7'd26: r = 4'd4;  7'd27: r = 4'd3;
            7'd28: r = 4'd5;  7'd29: r = 4'd2;  7'd30: r = 4'd5;  7'd31: r = 4'd3;
            7'd32: r = 4'd4;  7'd33: r = 4'd5;  7'd34: r = 4'd6;  7'd35: r = 4'd7;
            7'd36: r = 4'd1;  7'd37: r = 4'd8;  7'd38: r = 4'd7;  7'd39: r = 4'd6;
            7'd40: r = 4'd5;  7'd41: r = 4'd4;  7'd42: r = 4'd7;  7'd43: r = 4'd3;
            7'd44: r = 4'd8;  7'd45: r = 4'd5;  7'd46: r = 4'd7;  7'd47: r = 4'd9;
            7'd48: r = 4'd2;  7'd49: r = 4'd9;  7'd50: r = 4'd7;  7'd51: r = 4'd5;
            7'd52: r = 4'd8;  7'd53: r = 4'd11; 7'd54: r = 4'd3;  7'd55: r = 4'd10;
            7'd56: r = 4'd7;  7'd57: r = 4'd11; 7'd58: r = 4'd4;  7'd59: r = 4'd9;
            7'd60: r = 4'd5;  7'd61: r = 4'd11; 7'd62: r = 4'd6;  7'd63: r = 4'd13;
            7'd64: r = 4'd7;  7'd65: r = 4'd8;  7'd66: r = 4'd9;  7'd67: r = 4'd10;
            7'd68: r = 4'd11; 7'd69: r = 4'd12; 7'd70: r = 4'd13; 7'd71: r = 4'd14;
            default: r = 4'd0;
        endcase
        return r;
    endfunction

    function automatic frac_t rom_mul(input logic [6:0] idx);
        frac_t r;
        unique case (idx)
            7'd0:  r = 4'd1;  7'd1:  r = 4'd15; 7'd2:  r = 4'd14; 7'd3:  r = 4'd13;
            7'd4:  r = 4'd12; 7'd5:  r = 4'd11; 7'd6:  r = 4'd10; 7'd7:  r = 4'd9;
            7'd8:  r = 4'd8;  7'd9:  r = 4'd15; 7'd10: r = 4'd7;  7'd11: r = 4'd13;
            7'd12: r = 4'd6;  7'd13: r = 4'd11; 7'd14: r = 4'd5;  7'd15: r = 4'd14;
            7'd16: r = 4'd9;  7'd17: r = 4'd13; 7'd18: r = 4'd4;  7'd19: r = 4'd15;
            7'd20: r = 4'd11; 7'd21: r = 4'd7;  7'd22: r = 4'd10; 7'd23: r = 4'd13;
            7'd24: r = 4'd3;  7'd25: r = 4'd14; 7'd26: r = 4'd11; 7'd27: r = 4'd8;
            7'd28: r = 4'd13; 7'd29: r = 4'd5;  7'd30: r = 4'd12; 7'd31: r = 4'd7;
            7'd32: r = 4'd9;  7'd33: r = 4'd11; 7'd34: r = 4'd13; 7'd35: r = 4'd15;
            7'd36: r = 4'd2;  7'd37: r = 4'd15; 7'd38: r = 4'd13; 7'd39: r = 4'd11;
            7'd40: r = 4'd9;  7'd41: r = 4'd7;  7'd42: r = 4'd12; 7'd43: r = 4'd5;
            7'd44: r = 4'd13; 7'd45: r = 4'd8;  7'd46: r = 4'd11; 7'd47: r = 4'd14;
            7'd48: r = 4'd3;  7'd49: r = 4'd13; 7'd50: r = 4'd10; 7'd51: r = 4'd7;
            7'd52: r = 4'd11; 7'd53: r = 4'd15; 7'd54: r = 4'd4;  7'd55: r = 4'd13;
            7'd56: r = 4'd9;  7'd57: r = 4'd14; 7'd58: r = 4'd5;  7'd59: r = 4'd11;
            7'd60: r = 4'd6;  7'd61: r = 4'd13; 7'd62: r = 4'd7;  7'd63: r = 4'd15;
            7'd64: r = 4'd8;  7'd65: r = 4'd9;  7'd66: r = 4'd10; 7'd67: r = 4'd11;
            7'd68: r = 4'd12; 7'd69: r = 4'd13; 7'd70: r = 4'd14; 7'd71: r = 4'd15;
            default: r = 4'd1;
        endcase
        return r;
    endfunction

endpackage

/* sv/fbds_divider.sv */
// ============================================================================
// fbds_divider - shared restoring divider
// Unsigned radix-2 division, one quotient bit per cycle.
// ============================================================================
module fbds_divider (
    input  logic              aclk,
    input  logic              aresetn,
    input  fbds_pkg::div_req_t req,
    output fbds_pkg::div_rsp_t rsp
);
    import fbds_pkg::*;

    logic [DIV_W-1:0]     rem_reg, rem_next;
    logic [DIV_W-1:0]     quo_reg, quo_next;
    logic [DIV_W-1:0]     den_reg, den_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_W:0]       trial;
    logic [DIV_W:0]       diff;

    assign trial = {rem_reg, quo_reg[DIV_W-1]};
    assign diff  = trial - {1'b0, den_reg};

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            rem_next  = '0;
            quo_next  = req.dividend;
            den_next  = req.divisor;
            cnt_next  = DIV_CNT_W'(DIV_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            // shift in the next dividend bit; keep the difference if it did not go negative
            if (!diff[DIV_W]) begin
                rem_next = diff[DIV_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b1};
            end else begin
                rem_next = trial[DIV_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

/* sv/fractional_baud_divisor_search_core.sv */
// ============================================================================
// fractional_baud_divisor_search_core - UART fractional baud divisor search
// Walks the fractional-divider ROM and picks the pair with the smallest rate error.
// ============================================================================
//  channel  | ports                               | role
//  ---------+-------------------------------------+-------------------------
//  s_       | s_valid s_ready s_baud_rate         | requested baud rate in
//  m_       | m_valid m_ready m_divisor_latch ... | divisor, pair, success
//  cfg_     | cfg_valid cfg_ready cfg_data        | peripheral clock in Hz
//
//  Each ROM entry takes a pass through the shared divider for the divisor
//  latch (started from ST_DL) and, unless that divisor is zero, a second pass
//  for the achieved rate (started from ST_RATE); a zero baud skips the search.
//  s_ready is high only while the sequencer is idle and no result is pending.
//  A result waits in the output register until m_ready; reset clears it.
module fractional_baud_divisor_search_core #(
    parameter int TABLE_ENTRIES = fbds_pkg::TABLE_ENTRIES_DEF,
    parameter int OVERSAMPLE    = fbds_pkg::OVERSAMPLE_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [fbds_pkg::BAUD_W-1:0]   s_baud_rate,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [fbds_pkg::DL_W-1:0]     m_divisor_latch,
    output logic [fbds_pkg::FRAC_W-1:0]   m_div_add,
    output logic [fbds_pkg::FRAC_W-1:0]   m_mul_val,
    output logic                          m_success,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [fbds_pkg::CLOCK_W-1:0]  cfg_data
);
    import fbds_pkg::*;

    localparam int N_ENTRIES = (TABLE_ENTRIES > ROM_SIZE) ? ROM_SIZE : TABLE_ENTRIES;
    localparam int OVER_EFF  = (OVERSAMPLE == 0) ? 1 : OVERSAMPLE;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_DL    = 6'b000010,
        ST_DLW   = 6'b000100,
        ST_RATE  = 6'b001000,
        ST_RATEW = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

    state_t               state_reg, state_next;
    logic [CLOCK_W-1:0]   clock_reg;
    logic [BAUD_W-1:0]    baud_reg, baud_next;
    logic [6:0]           idx_reg, idx_next;
    logic [DIV_W-1:0]     dl_reg, dl_next;
    logic                 found_reg, found_next;
    logic [DIV_W-1:0]     best_err_reg, best_err_next;
    logic [DIV_W-1:0]     best_dl_reg, best_dl_next;
    logic [6:0]           best_idx_reg, best_idx_next;
    logic                 m_valid_reg, m_valid_next;
    logic [DL_W-1:0]      o_dl_reg, o_dl_next;
    logic [FRAC_W-1:0]    o_add_reg, o_add_next;
    logic [FRAC_W-1:0]    o_mul_reg, o_mul_next;
    logic                 o_ok_reg, o_ok_next;

    div_req_t             req;
    div_rsp_t             rsp;

    frac_t                cur_mul, cur_add;
    logic [FRAC_W:0]      cur_sum;
    logic [DIV_W-1:0]     num_dl;
    logic [DIV_W-1:0]     den_dl;
    logic [DIV_W-1:0]     den_rate;
    logic [DIV_W-1:0]     target;
    logic [DIV_W-1:0]     err;
    logic                 last_entry;

    assign cur_mul  = rom_mul(idx_reg);
    assign cur_add  = rom_add(idx_reg);
    assign cur_sum  = {1'b0, cur_mul} + {1'b0, cur_add};
    assign num_dl   = DIV_W'(clock_reg) * DIV_W'(cur_mul);
    assign den_dl   = DIV_W'(baud_reg) * DIV_W'(OVER_EFF * 1) * DIV_W'(cur_sum);
    assign den_rate = dl_reg[27:0] * DIV_W'(cur_sum) * DIV_W'(OVER_EFF * 1);
    assign target   = {8'h00, baud_reg, 8'h00};
    assign err      = (rsp.quotient >= target) ? rsp.quotient - target
                                               : target - rsp.quotient;
    assign last_entry = (idx_reg == 7'(N_ENTRIES - 1));

    fbds_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (req),
        .rsp     (rsp)
    );

    always_comb begin
        state_next    = state_reg;
        baud_next     = baud_reg;
        idx_next      = idx_reg;
        dl_next       = dl_reg;
        found_next    = found_reg;
        best_err_next = best_err_reg;
        best_dl_next  = best_dl_reg;
        best_idx_next = best_idx_reg;
        m_valid_next  = m_valid_reg;
        o_dl_next     = o_dl_reg;
        o_add_next    = o_add_reg;
        o_mul_next    = o_mul_reg;
        o_ok_next     = o_ok_reg;
        req.start     = 1'b0;
        req.dividend  = num_dl;
        req.divisor   = den_dl;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && !m_valid_reg) begin
                    baud_next  = s_baud_rate;
                    idx_next   = '0;
                    found_next = 1'b0;
                    state_next = (s_baud_rate == '0) ? ST_DONE : ST_DL;
                end
            end
            ST_DL: begin
                req.start  = 1'b1;
                state_next = ST_DLW;
            end
            ST_DLW: begin
                if (rsp.done) begin
                    dl_next = rsp.quotient;
                    // skip pairs whose divisor rounds down to zero
                    if (rsp.quotient == '0) begin
                        if (last_entry) state_next = ST_DONE;
                        else begin
                            idx_next   = idx_reg + 1'b1;
                            state_next = ST_DL;
                        end
                    end else begin
                        state_next = ST_RATE;
                    end
                end
            end
            ST_RATE: begin
                req.start    = 1'b1;
                req.dividend = {num_dl[DIV_W-9:0], 8'h00};
                req.divisor  = den_rate;
                state_next   = ST_RATEW;
            end
            ST_RATEW: begin
                if (rsp.done) begin
                    if (!found_reg || err < best_err_reg) begin
                        found_next    = 1'b1;
                        best_err_next = err;
                        best_dl_next  = dl_reg;
                        best_idx_next = idx_reg;
                    end
                    if (last_entry) state_next = ST_DONE;
                    else begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_DL;
                    end
                end
            end
            ST_DONE: begin
                m_valid_next = 1'b1;
                if (found_reg && best_dl_reg <= DIV_W'(16'hFFFF)) begin
                    o_dl_next  = best_dl_reg[DL_W-1:0];
                    o_add_next = rom_add(best_idx_reg);
                    o_mul_next = rom_mul(best_idx_reg);
                    o_ok_next  = 1'b1;
                end else begin
                    o_dl_next  = '0;
                    o_add_next = '0;
                    o_mul_next = FRAC_W'(1);
                    o_ok_next  = 1'b0;
                end
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            found_reg   <= 1'b0;
            clock_reg   <= CLOCK_RESET;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            found_reg   <= found_next;
            if (cfg_valid && cfg_ready) clock_reg <= cfg_data;
        end
        baud_reg     <= baud_next;
        idx_reg      <= idx_next;
        dl_reg       <= dl_next;
        best_err_reg <= best_err_next;
        best_dl_reg  <= best_dl_next;
        best_idx_reg <= best_idx_next;
        o_dl_reg     <= o_dl_next;
        o_add_reg    <= o_add_next;
        o_mul_reg    <= o_mul_next;
        o_ok_reg     <= o_ok_next;
    end

    assign s_ready         = (state_reg == ST_IDLE) && !m_valid_reg;
    assign cfg_ready       = 1'b1;
    assign m_valid         = m_valid_reg;
    assign m_divisor_latch = o_dl_reg;
    assign m_div_add       = o_add_reg;
    assign m_mul_val       = o_mul_reg;
    assign m_success       = o_ok_reg;

    // an accepted transaction always moves the sequencer out of idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg != ST_IDLE))
        else $error("sequencer did not start");
    // a failed search reports the fixed failure fields
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_success) |-> (m_divisor_latch == '0 && m_mul_val == FRAC_W'(1)))
        else $error("failure fields wrong");
    // a successful search never reports a zero divisor
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_success) |-> (m_divisor_latch != '0))
        else $error("zero divisor reported as success");
    // the divider only finishes while the sequencer waits on it
    assert property (@(posedge aclk) disable iff (!aresetn)
        rsp.done |-> (state_reg == ST_DLW || state_reg == ST_RATEW))
        else $error("unexpected divider completion");

endmodule

/* sim/tb.sv */
// ----------------------------------------------------------------------------
// tb - fractional baud divisor search core testbench
// Feeds baud-rate requests under several clock settings, predicts the chosen
// divisor and fractional pair, and checks every returned transaction.
// ----------------------------------------------------------------------------
module tb;
    import fbds_pkg::*;

    typedef struct packed {
        logic [DL_W-1:0]   dl;
        logic [FRAC_W-1:0] add;
        logic [FRAC_W-1:0] mul;
        logic              ok;
    } pick_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [BAUD_W-1:0] s_baud_rate = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [DL_W-1:0] m_divisor_latch;
    logic [FRAC_W-1:0] m_div_add, m_mul_val;
    logic m_success;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CLOCK_W-1:0] cfg_data = '0;

    logic [CLOCK_W-1:0] clk_hz;
    logic [BAUD_W-1:0] pending_baud[$];
    pick_t expected_picks[$];
    int errors = 0;
    int cycles = 0;
    int hold_off = 0;
    bit feeding = 1'b0;
    bit long_hold_armed = 1'b0;
    bit long_hold_done = 1'b0;
    int send_gap = 0, recv_gap = 0;

    fractional_baud_divisor_search_core u_top (.*);

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > 10000000) begin
            $display("fractional_baud_divisor_search_core test failed");
            $finish;
        end
    end

    function automatic pick_t search_divisor(input logic [BAUD_W-1:0] baud,
                                             input logic [CLOCK_W-1:0] clk);
        pick_t p;
        logic [63:0] m, s, dl, rate, tgt, err, best_err, best_dl;
        int best_i;
        bit found;
        found = 0; best_err = 0; best_dl = 0; best_i = 0;
        if (baud != 0) begin
            for (int i = 0; i < ROM_SIZE; i++) begin
                m = 64'(rom_mul(7'(i)));
                s = m + 64'(rom_add(7'(i)));
                dl = (64'(clk) * m) / (64'(OVERSAMPLE_DEF) * 64'(baud) * s);
                if (dl == 0) continue;
                rate = ((64'(clk) * m) << 8) / (64'(OVERSAMPLE_DEF) * dl * s);
                tgt = 64'(baud) << 8;
                err = (rate >= tgt) ? rate - tgt : tgt - rate;
                if (!found || err < best_err) begin
                    found = 1; best_err = err; best_dl = dl; best_i = i;
                end
            end
        end
        if (found && best_dl <= 64'd65535) begin
            p.dl = best_dl[15:0];
            p.add = rom_add(7'(best_i));
            p.mul = rom_mul(7'(best_i));
            p.ok = 1'b1;
        end else begin
            p = '{dl: '0, add: '0, mul: 4'd1, ok: 1'b0};
        end
        return p;
    endfunction

    function automatic int pick_gap();
        if ($urandom_range(0, 9) < 5) return 0;
        if ($urandom_range(0, 9) < 8) return $urandom_range(1, 4);
        return $urandom_range(10, 60);
    endfunction

    // record the expected result of every accepted request
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            expected_picks.push_back(search_divisor(s_baud_rate, clk_hz));
        end
    end

    // driver: present next request at falling edge, hold until accepted
    bit sent;
    always @(negedge aclk) begin
        if (s_valid && sent) begin
            s_valid <= 1'b0;
        end else if (!s_valid) begin
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
            end else if (feeding && pending_baud.size() > 0) begin
                s_baud_rate <= pending_baud.pop_front();
                s_valid <= 1'b1;
                send_gap <= pick_gap();
            end
        end
    end
    always @(posedge aclk) sent <= s_valid && s_ready && aresetn;

    // monitor and receiver
    always @(posedge aclk) begin
        pick_t exp_p;
        if (aresetn && m_valid && m_ready) begin
            if (expected_picks.size() == 0) begin
                $display("%0t: unexpected result dl=%0d", $time, m_divisor_latch);
                errors <= errors + 1;
            end else begin
                exp_p = expected_picks.pop_front();
                if (exp_p.dl !== m_divisor_latch || exp_p.add !== m_div_add ||
                    exp_p.mul !== m_mul_val || exp_p.ok !== m_success) begin
                    $display("%0t: mismatch exp dl=%0d add=%0d mul=%0d ok=%0d",
                             $time, exp_p.dl, exp_p.add, exp_p.mul, exp_p.ok,
                             " got dl=%0d add=%0d mul=%0d ok=%0d",
                             m_divisor_latch, m_div_add, m_mul_val, m_success);
                    errors <= errors + 1;
                end
            end
        end
    end

    // long receiver stall, counted on its own
    always @(negedge aclk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
        end else if (long_hold_armed && !long_hold_done) begin
            hold_off <= 20000;
            long_hold_done <= 1'b1;
        end
    end

    always @(negedge aclk) begin
        if (hold_off > 0) begin
            m_ready <= 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) recv_gap <= pick_gap();
        end
    end

    task automatic write_clock(input logic [CLOCK_W-1:0] v);
        @(negedge aclk);
        cfg_data <= v;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        clk_hz = v;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase();
        feeding = 1'b1;
        wait (pending_baud.size() == 0 && !s_valid);
        feeding = 1'b0;
        wait (expected_picks.size() == 0);
        repeat (20) @(posedge aclk);
    endtask

    function automatic logic [BAUD_W-1:0] rand_baud();
        case ($urandom_range(0, 5))
            0: return BAUD_W'($urandom_range(1, 300));
            1, 2: return BAUD_W'($urandom_range(300, 921600));
            3: return BAUD_W'($urandom);
            4: return BAUD_W'($urandom_range(0, 8));
            default: return BAUD_W'(1) << $urandom_range(0, 23);
        endcase
    endfunction

    initial begin
        logic [CLOCK_W-1:0] clocks[6];
        clocks = '{28'd25000000, 28'hFFFFFFF, 28'd1, 28'd0, 28'd100000000, 28'd14745600};
        clk_hz = CLOCK_RESET;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed requests at the reset clock
        pending_baud = '{24'd0, 24'd1, 24'hFFFFFF, 24'd115200, 24'd9600,
                         24'd1562500, 24'd1562501, 24'd3, 24'hAAAAAA, 24'h555555,
                         24'd300, 24'd921600};
        run_phase();
        for (int c = 1; c < 6; c++) begin
            write_clock(clocks[c]);
            pending_baud = '{24'd0, 24'd1, 24'd2, 24'hFFFFFF, 24'd115200};
            for (int k = 0; k < 30; k++) pending_baud.push_back(rand_baud());
            if (c == 4) begin
                long_hold_armed = 1'b1;
                for (int k = 0; k < 5; k++) pending_baud.push_back(24'd9600);
            end
            run_phase();
        end
        write_clock(CLOCK_W'($urandom));
        for (int k = 0; k < 25; k++) pending_baud.push_back(rand_baud());
        run_phase();

        if (errors == 0)
            $display("fractional_baud_divisor_search_core test passed");
        else
            $display("fractional_baud_divisor_search_core test failed");
        $finish;
    end
endmodule

/* filelist.f */
sv/fbds_pkg.sv
sv/fbds_divider.sv
sv/fractional_baud_divisor_search_core.sv
sim/tb.sv
